// ----- rtl/core/pip_pkg.sv -----
// Shared types and constants for the point-in-polygon test block.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none
package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 24;
  localparam int ADDR_BITS    = $clog2(MAX_VERTICES);
  localparam int CNT_BITS     = 7;

  // Widths of a coordinate difference, of an edge cross product term and of the difference of two terms
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int PROD_BITS = 2 * DIFF_BITS;
  localparam int CMP_BITS  = PROD_BITS + 1;

  // Value of the S_DRAIN counter at which the controller raises done and returns to idle
  localparam logic [1:0] PIPE_DRAIN = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic ST_OK        = 1'b0;
  localparam logic ST_BAD_INDEX = 1'b1;

  typedef struct packed {
    logic                 load_write;
    logic                 load_query;
    logic                 rd_en;
    logic                 rd_first;
    logic [ADDR_BITS-1:0] rd_addr;
  } pip_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/core/pip_ctrl.sv -----
// Controller for the point-in-polygon test: accepts commands, holds vertex_count,
// sequences the vertex walk and raises done. Depends on pip_pkg.
`default_nettype none
module pip_ctrl
  import pip_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic                cmd,
  input  wire logic                cfg_valid,
  input  wire logic [CNT_BITS-1:0] cfg_data,
  output logic                     cfg_ready,
  output logic                     busy,
  output logic                     done,
  output pip_cmd_t                 dp_cmd
);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DRAIN} state_t;

  state_t               state;
  logic [ADDR_BITS-1:0] addr;
  logic [ADDR_BITS-1:0] last_addr;
  logic [1:0]           drain;
  logic [CNT_BITS-1:0]  vcount;

  logic                accept;
  logic [CNT_BITS-1:0] n_eff;
  logic [CNT_BITS-1:0] n_last;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;

  // Clamp the configured count to the table size
  assign n_eff  = (vcount > CNT_BITS'(MAX_VERTICES)) ? CNT_BITS'(MAX_VERTICES) : vcount;
  assign n_last = n_eff - CNT_BITS'(1);

  assign dp_cmd.load_write = accept && (cmd == CMD_WRITE);
  assign dp_cmd.load_query = accept && (cmd == CMD_QUERY);
  assign dp_cmd.rd_en      = (state == S_WALK);
  assign dp_cmd.rd_first   = (addr == '0);
  assign dp_cmd.rd_addr    = addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      vcount <= '0;
      addr   <= '0;
      drain  <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        vcount <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd == CMD_WRITE || n_eff < CNT_BITS'(2)) begin
              done <= 1'b1;
            end else begin
              state     <= S_WALK;
              addr      <= '0;
              last_addr <= n_last[ADDR_BITS-1:0];
            end
          end
        end
        S_WALK: begin
          addr <= addr + ADDR_BITS'(1);
          if (addr == last_addr) begin
            state <= S_DRAIN;
            drain <= '0;
          end
        end
        S_DRAIN: begin
          // Wait for the last edge to leave the pipeline
          drain <= drain + 2'd1;
          if (drain == PIPE_DRAIN) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/pip_dp.sv -----
// Datapath for the point-in-polygon test: vertex memory, edge pipeline
// (differences, cross products, compare) and result registers. Depends on pip_pkg.
`default_nettype none
module pip_dp
  import pip_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire pip_cmd_t              dp_cmd,
  input  wire logic [ADDR_BITS-1:0]  vertex_index,
  input  wire logic [COORD_BITS-1:0] coord_x,
  input  wire logic [COORD_BITS-1:0] coord_y,
  output logic                       inside_res,
  output logic                       on_edge,
  output logic                       status
);

  logic [2*COORD_BITS-1:0] mem [MAX_VERTICES];

  logic                         wr_ok;
  logic signed [COORD_BITS-1:0] qx, qy;

  // Read stage
  logic                    rd_valid, rd_first;
  logic [2*COORD_BITS-1:0] rd_data;

  // Edge setup stage
  logic signed [COORD_BITS-1:0] prev_x, prev_y;
  logic signed [COORD_BITS-1:0] cur_x, cur_y;
  logic                         d_valid, d_box, d_cross, d_up, d_down;
  logic signed [DIFF_BITS-1:0]  d_dx, d_dyp, d_dxp, d_dy;

  // Product stage
  logic                        m_valid, m_box, m_cross, m_up, m_down;
  logic signed [PROD_BITS-1:0] m_p, m_q;

  // Compare stage
  logic signed [CMP_BITS-1:0] cmp_diff;
  logic                       c_gt, c_lt, c_eq;
  logic                       inside_acc;

  assign wr_ok = ({1'b0, vertex_index} < CNT_BITS'(MAX_VERTICES));

  always_ff @(posedge clk) begin
    if (dp_cmd.load_write && wr_ok) begin
      mem[vertex_index] <= {coord_x, coord_y};
    end
    if (dp_cmd.rd_en) begin
      rd_data <= mem[dp_cmd.rd_addr];
    end
  end

  assign cur_x = $signed(rd_data[2*COORD_BITS-1:COORD_BITS]);
  assign cur_y = $signed(rd_data[COORD_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      rd_first <= 1'b0;
      d_valid  <= 1'b0;
      m_valid  <= 1'b0;
    end else begin
      rd_valid <= dp_cmd.rd_en;
      rd_first <= dp_cmd.rd_first;
      d_valid  <= rd_valid && !rd_first;
      m_valid  <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load_query) begin
      qx <= $signed(coord_x);
      qy <= $signed(coord_y);
    end
    if (rd_valid) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
    // Edge runs from the previous vertex to the one just read
    d_dx    <= DIFF_BITS'(cur_x) - DIFF_BITS'(prev_x);
    d_dyp   <= DIFF_BITS'(qy) - DIFF_BITS'(prev_y);
    d_dxp   <= DIFF_BITS'(qx) - DIFF_BITS'(prev_x);
    d_dy    <= DIFF_BITS'(cur_y) - DIFF_BITS'(prev_y);
    d_box   <= ((qx >= prev_x && qx <= cur_x) || (qx >= cur_x && qx <= prev_x)) &&
               ((qy >= prev_y && qy <= cur_y) || (qy >= cur_y && qy <= prev_y));
    d_cross <= (prev_y > qy) != (cur_y > qy);
    d_up    <= cur_y > prev_y;
    d_down  <= cur_y < prev_y;

    m_p     <= PROD_BITS'(d_dx) * PROD_BITS'(d_dyp);
    m_q     <= PROD_BITS'(d_dxp) * PROD_BITS'(d_dy);
    m_box   <= d_box;
    m_cross <= d_cross;
    m_up    <= d_up;
    m_down  <= d_down;
  end

  assign cmp_diff = CMP_BITS'(m_p) - CMP_BITS'(m_q);
  assign c_eq     = (cmp_diff == '0);
  assign c_gt     = !c_eq && !cmp_diff[CMP_BITS-1];
  assign c_lt     = cmp_diff[CMP_BITS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      on_edge    <= 1'b0;
      inside_acc <= 1'b0;
      status     <= ST_OK;
    end else if (dp_cmd.load_write) begin
      on_edge    <= 1'b0;
      inside_acc <= 1'b0;
      status     <= wr_ok ? ST_OK : ST_BAD_INDEX;
    end else if (dp_cmd.load_query) begin
      on_edge    <= 1'b0;
      inside_acc <= 1'b0;
      status     <= ST_OK;
    end else if (m_valid) begin
      // Once on an edge the answer is settled; later toggles are masked at the output
      if (c_eq && m_box) begin
        on_edge <= 1'b1;
      end else if (m_cross && ((m_up && c_gt) || (m_down && c_lt))) begin
        inside_acc <= !inside_acc;
      end
    end
  end

  assign inside_res = on_edge || inside_acc;

endmodule
`default_nettype wire

// ----- rtl/core/point_in_polygon_test.sv -----
// Top level of the point-in-polygon test block.
// Depends on pip_pkg, pip_ctrl and pip_dp.
//
// Usage:
//   Commands are accepted on a rising edge with start high and busy low.
//   cmd selects a vertex write (vertex_index, coord_x, coord_y) or a point
//   query (coord_x, coord_y). Each command returns one result beat: done is
//   high for exactly one cycle with inside_res, on_edge and status valid.
//   The receiver cannot stall; capture the beat in the cycle done is high.
//   vertex_count is written on the cfg channel (cfg_ready is always high);
//   the user must do so only while no command is in flight; not enforced.
// Timing:
//   A vertex write returns done in the cycle after acceptance and never
//   raises busy. A query with n = min(vertex_count, 64) below two returns in
//   the next cycle; otherwise busy covers the walk of all n vertices through
//   the single vertex memory read port, one vertex per cycle, and the drain
//   of a three stage edge pipeline (setup, cross products, compare); done
//   follows in the cycle busy drops.
// Reset:
//   rst clears vertex_count and the controller; vertex memory is not cleared.
`default_nettype none
module point_in_polygon_test
  import pip_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  cmd,
  input  wire logic [ADDR_BITS-1:0]  vertex_index,
  input  wire logic [COORD_BITS-1:0] coord_x,
  input  wire logic [COORD_BITS-1:0] coord_y,
  output logic                       done,
  output logic                       inside_res,
  output logic                       on_edge,
  output logic                       status,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CNT_BITS-1:0]   cfg_data
);

  pip_cmd_t dp_cmd;

  pip_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .busy      (busy),
    .done      (done),
    .dp_cmd    (dp_cmd)
  );

  pip_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .dp_cmd       (dp_cmd),
    .vertex_index (vertex_index),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .inside_res   (inside_res),
    .on_edge      (on_edge),
    .status       (status)
  );

endmodule
`default_nettype wire

// ----- tb/point_in_polygon_test_tb.sv -----
// Self-checking testbench for point_in_polygon_test: vertex writes and point queries
// are predicted by an even-odd crossing scoreboard and every result beat is checked.
// Depends on pip_pkg and the point_in_polygon_test RTL.
module point_in_polygon_test_tb
  import pip_pkg::*;
;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 1300;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic in_poly;
    logic hit;
    logic st;
  } verdict_t;

  class polygon_scoreboard;
    coord_t      vx [MAX_VERTICES];
    coord_t      vy [MAX_VERTICES];
    int unsigned vcount;
    verdict_t    pending_verdicts [$];
    int          mismatches;
    int          commands;
    int          queries;
    int          inside_hits;
    int          edge_hits;

    function new();
      for (int i = 0; i < MAX_VERTICES; i++) begin
        vx[i] = '0;
        vy[i] = '0;
      end
      vcount      = 0;
      mismatches  = 0;
      commands    = 0;
      queries     = 0;
      inside_hits = 0;
      edge_hits   = 0;
    endfunction

    // Walk edges (i, i+1) and count crossings of the ray toward +x.
    function void locate_point(input coord_t qx, input coord_t qy,
                               output logic in_poly, output logic hit);
      int     n;
      int     side;
      longint px, py, x1, y1, x2, y2, lhs, rhs, xlo, xhi, ylo, yhi;
      in_poly = 1'b0;
      hit     = 1'b0;
      px      = longint'(qx);
      py      = longint'(qy);
      n       = (vcount > MAX_VERTICES) ? MAX_VERTICES : int'(vcount);
      for (int i = 0; i + 1 < n; i++) begin
        x1   = longint'(vx[i]);
        y1   = longint'(vy[i]);
        x2   = longint'(vx[i+1]);
        y2   = longint'(vy[i+1]);
        lhs  = (x2 - x1) * (py - y1);
        rhs  = (px - x1) * (y2 - y1);
        side = (lhs > rhs) ? 1 : ((lhs < rhs) ? -1 : 0);
        xlo  = (x1 < x2) ? x1 : x2;
        xhi  = (x1 < x2) ? x2 : x1;
        ylo  = (y1 < y2) ? y1 : y2;
        yhi  = (y1 < y2) ? y2 : y1;
        if (side == 0 && px >= xlo && px <= xhi && py >= ylo && py <= yhi) begin
          hit = 1'b1;
          break;
        end
        // half-open y span: a shared vertex is counted on one edge only
        if ((y1 > py) != (y2 > py)) begin
          if ((y2 > y1 && side > 0) || (y2 < y1 && side < 0))
            in_poly = ~in_poly;
        end
      end
    endfunction

    function void note_command(input logic op, input logic [ADDR_BITS-1:0] idx,
                               input coord_t x, input coord_t y);
      verdict_t v;
      logic     crossed;
      logic     touched;
      v = '0;
      commands++;
      if (op == CMD_WRITE) begin
        if (int'(idx) < MAX_VERTICES) begin
          vx[idx] = x;
          vy[idx] = y;
          v.st    = ST_OK;
        end else begin
          v.st = ST_BAD_INDEX;
        end
      end else begin
        queries++;
        locate_point(x, y, crossed, touched);
        v.in_poly = crossed | touched;
        v.hit     = touched;
        v.st      = ST_OK;
        if (v.in_poly) inside_hits++;
        if (v.hit) edge_hits++;
      end
      pending_verdicts = {pending_verdicts, v};
    endfunction

    task flag_mismatch(input string msg);
      if (mismatches < 40)
        $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_verdict(input logic got_in, input logic got_hit, input logic got_st);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        flag_mismatch("result beat with no command outstanding");
        return;
      end
      want = pending_verdicts.pop_front();
      if (got_in !== want.in_poly)
        flag_mismatch($sformatf("inside_res %b, expected %b", got_in, want.in_poly));
      if (got_hit !== want.hit)
        flag_mismatch($sformatf("on_edge %b, expected %b", got_hit, want.hit));
      if (got_st !== want.st)
        flag_mismatch($sformatf("status %b, expected %b", got_st, want.st));
    endtask
  endclass

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  start        = 1'b0;
  logic                  cmd          = CMD_WRITE;
  logic [ADDR_BITS-1:0]  vertex_index = '0;
  coord_t                coord_x      = '0;
  coord_t                coord_y      = '0;
  logic                  cfg_valid    = 1'b0;
  logic [CNT_BITS-1:0]   cfg_data     = '0;
  logic                  busy;
  logic                  done;
  logic                  inside_res;
  logic                  on_edge;
  logic                  status;
  logic                  cfg_ready;

  polygon_scoreboard sb = new();
  int cycles          = 0;
  int burst_left      = 0;
  int count_settings  = 0;

  point_in_polygon_test dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .vertex_index (vertex_index),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .done         (done),
    .inside_res   (inside_res),
    .on_edge      (on_edge),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done)
      sb.check_verdict(inside_res, on_edge, status);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic coord_t to_coord(input int v);
    return coord_t'(v);
  endfunction

  // Coordinate classes: coarse grid (shared lines are common), mid range,
  // full range, and the extremes of the field.
  function automatic coord_t rand_coord(input int scale);
    int v;
    case (scale)
      0: v = int'($urandom_range(0, 32)) * 8 - 128;
      1: v = int'($urandom_range(0, 4096)) - 2048;
      2: v = int'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0: v = int'(COORD_MAX);
          1: v = int'(COORD_MIN);
          2: v = 0;
          3: v = -1;
          default: v = int'($urandom);
        endcase
      end
    endcase
    return coord_t'(v);
  endfunction

  // Call at a falling edge; returns at the falling edge after the command is accepted.
  task automatic send_command(input logic op, input logic [ADDR_BITS-1:0] idx,
                              input coord_t x, input coord_t y);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
      if (gap > 0) begin
        start = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    start        = 1'b1;
    cmd          = op;
    vertex_index = idx;
    coord_x      = x;
    coord_y      = y;
    do @(posedge clk); while (busy);
    sb.note_command(op, idx, x, y);
    @(negedge clk);
  endtask

  task automatic finish_outstanding();
    start = 1'b0;
    while (sb.pending_verdicts.size() != 0) @(negedge clk);
  endtask

  task automatic set_vertex_count(input int unsigned n);
    cfg_valid = 1'b1;
    cfg_data  = n[CNT_BITS-1:0];
    do @(posedge clk); while (!cfg_ready);
    sb.vcount = n[CNT_BITS-1:0];
    count_settings++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    int          sent;
    int          n;
    int          n_used;
    int          scale;
    int          burst;
    int          i;
    int          pick;
    logic        closed;
    longint      sx;
    longint      sy;
    coord_t      x;
    coord_t      y;
    coord_t      x0;
    coord_t      y0;
    int unsigned count_plan [12];

    count_plan = '{2, 3, 64, 127, 65, 4, 5, 0, 1, 9, 33, 100};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty table, then a closed square with a degenerate first edge.
    send_command(CMD_QUERY, '1, to_coord(0), to_coord(0));
    send_command(CMD_WRITE, 6'd0, to_coord(0), to_coord(0));
    send_command(CMD_WRITE, 6'd1, to_coord(0), to_coord(0));
    send_command(CMD_WRITE, 6'd2, to_coord(160), to_coord(0));
    send_command(CMD_WRITE, 6'd3, to_coord(160), to_coord(160));
    send_command(CMD_WRITE, 6'd4, to_coord(0), to_coord(160));
    send_command(CMD_WRITE, 6'd5, to_coord(0), to_coord(0));
    finish_outstanding();
    set_vertex_count(1);
    send_command(CMD_QUERY, '0, to_coord(0), to_coord(0));
    finish_outstanding();
    set_vertex_count(6);
    send_command(CMD_QUERY, '0, to_coord(80), to_coord(80));
    send_command(CMD_QUERY, '0, to_coord(320), to_coord(80));
    send_command(CMD_QUERY, '0, to_coord(0), to_coord(0));
    send_command(CMD_QUERY, '0, to_coord(80), to_coord(0));
    send_command(CMD_QUERY, '0, to_coord(160), to_coord(80));
    send_command(CMD_QUERY, '0, to_coord(-16), to_coord(0));
    send_command(CMD_QUERY, '0, to_coord(-16), to_coord(160));
    send_command(CMD_QUERY, '0, to_coord(80), to_coord(-16));
    send_command(CMD_QUERY, '1, COORD_MAX, COORD_MAX);
    send_command(CMD_QUERY, '1, COORD_MIN, COORD_MIN);
    send_command(CMD_WRITE, 6'd63, COORD_MIN, COORD_MAX);
    send_command(CMD_WRITE, 6'd62, COORD_MAX, COORD_MIN);
    finish_outstanding();

    // Random phases: load a polygon, set the count, then mixed traffic.
    sent = 0;
    i    = 0;
    while (sent < RANDOM_ITEMS) begin
      if (i < 12) begin
        n = count_plan[i];
      end else begin
        pick = $urandom_range(0, 19);
        if (pick == 0) n = $urandom_range(0, 127);
        else if (pick < 3) n = $urandom_range(0, 1);
        else n = $urandom_range(2, 12);
      end
      i++;
      scale  = $urandom_range(0, 3);
      closed = ($urandom_range(0, 3) != 0);
      n_used = (n > MAX_VERTICES) ? MAX_VERTICES : n;
      // every slot in use is written before the count covers it
      for (int k = 0; k < ((n_used < 2) ? 2 : n_used); k++) begin
        x = rand_coord(scale);
        y = rand_coord(scale);
        if (k == 0) begin
          x0 = x;
          y0 = y;
        end else if (closed && k == n_used - 1) begin
          x = x0;
          y = y0;
        end
        send_command(CMD_WRITE, k[ADDR_BITS-1:0], x, y);
        sent++;
      end
      finish_outstanding();
      set_vertex_count(n);

      burst = $urandom_range(20, 60);
      repeat (burst) begin
        if ($urandom_range(0, 6) == 0) begin
          send_command(CMD_WRITE, ADDR_BITS'($urandom), rand_coord(scale), rand_coord(scale));
        end else begin
          x = rand_coord(scale);
          y = rand_coord(scale);
          if (n_used >= 2) begin
            pick = $urandom_range(0, 9);
            k_sel: begin
              int k;
              k = $urandom_range(0, n_used - 2);
              if (pick < 2) begin
                x = sb.vx[k];
                y = sb.vy[k];
              end else if (pick < 4) begin
                // level with a vertex: exercises the half-open span rule
                y = sb.vy[k];
              end else if (pick < 6) begin
                sx = longint'(sb.vx[k]) + longint'(sb.vx[k+1]);
                sy = longint'(sb.vy[k]) + longint'(sb.vy[k+1]);
                if (!sx[0] && !sy[0]) begin
                  x = coord_t'(sx >>> 1);
                  y = coord_t'(sy >>> 1);
                end else begin
                  x = sb.vx[k+1];
                  y = sb.vy[k+1];
                end
              end else if (pick == 6) begin
                x = rand_coord(2);
                y = rand_coord(2);
              end
            end
          end
          send_command(CMD_QUERY, ADDR_BITS'($urandom), x, y);
        end
        sent++;
      end
      finish_outstanding();
    end

    // drain: the longest query takes the full table plus the edge pipeline
    repeat (MAX_VERTICES + 8) @(negedge clk);
    if (sb.pending_verdicts.size() != 0)
      sb.flag_mismatch($sformatf("%0d results never arrived", sb.pending_verdicts.size()));

    $display("Ran %0d commands (%0d point queries) over %0d vertex_count settings.",
             sb.commands, sb.queries, count_settings);
    $display("Queries answered inside: %0d, on an edge: %0d; mismatches: %0d.",
             sb.inside_hits, sb.edge_hits, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/pip_pkg.sv
rtl/core/pip_ctrl.sv
rtl/core/pip_dp.sv
rtl/core/point_in_polygon_test.sv
tb/point_in_polygon_test_tb.sv
